// File: rtl/rcg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rcg_pkg;

   // grid geometry
   localparam int GRID_DIM   = 64;
   localparam int NUM_LAYERS = 4;
   localparam int IDX_W      = $clog2(GRID_DIM);
   localparam int CNT_W      = IDX_W + 1;
   localparam int LAYER_W    = 2;
   localparam int ADDR_W     = LAYER_W + 2 * IDX_W;
   localparam int BASE_W     = CNT_W + 16;

   // shared divider
   localparam int DIV_NUM_W  = 48;
   localparam int DIV_DEN_W  = 32;
   localparam int DIV_CNT_W  = $clog2(DIV_NUM_W);

   // opcodes
   localparam logic [1:0] OP_ADD   = 2'd0;
   localparam logic [1:0] OP_READ  = 2'd1;
   localparam logic [1:0] OP_CLEAR = 2'd2;

   // status codes
   localparam logic [1:0] ST_DONE     = 2'd0;
   localparam logic [1:0] ST_ZERO     = 2'd1;
   localparam logic [1:0] ST_INVERTED = 2'd2;

   // register indexes
   localparam logic [1:0] CSR_BIN_WIDTH  = 2'd0;
   localparam logic [1:0] CSR_BIN_HEIGHT = 2'd1;
   localparam logic [1:0] CSR_BIN_AREA   = 2'd2;

   typedef enum logic [4:0] {
      S_CLR,
      S_IDLE,
      S_MUL_SUM,
      S_MUL_AREA,
      S_DIV_GO,
      S_DIV_WAIT,
      S_RANGE,
      S_BIN,
      S_EDGE_BASE,
      S_EDGE_SPAN,
      S_EDGE_AREA,
      S_GAIN_MUL,
      S_GAIN_SAT,
      S_RD,
      S_WR,
      S_RD_WAIT,
      S_DONE
   } state_type;

   typedef enum logic [2:0] {
      DS_UTIL,
      DS_XL,
      DS_YL,
      DS_XU,
      DS_YU,
      DS_FRAC
   } div_sel_type;

   typedef struct packed {
      logic                 start;
      logic [DIV_NUM_W-1:0] num;
      logic [DIV_DEN_W-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic                 busy;
      logic                 done;
      logic [DIV_NUM_W-1:0] quot;
   } div_rsp_type;

   typedef struct packed {
      logic              we;
      logic [ADDR_W-1:0] waddr;
      logic [31:0]       wdata;
      logic              re;
      logic [ADDR_W-1:0] raddr;
   } mem_req_type;

endpackage

`default_nettype wire

// File: rtl/rcg_div.sv
`timescale 1ns / 1ps
`default_nettype none

module rcg_div (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  rcg_pkg::div_req_type      div_req,
   output rcg_pkg::div_rsp_type      div_rsp
);
   import rcg_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [DIV_NUM_W-1:0] num_ff, num_in;
   logic [DIV_DEN_W-1:0] rem_ff, rem_in;
   logic [DIV_DEN_W-1:0] den_ff, den_in;
   logic [DIV_DEN_W:0]   trial;
   logic                 qbit;

   // restoring division, one quotient bit a cycle
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      trial   = {rem_ff, num_ff[DIV_NUM_W-1]};
      qbit    = (trial >= {1'b0, den_ff});
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = DIV_CNT_W'(DIV_NUM_W - 1);
         num_in  = div_req.num;
         rem_in  = '0;
         den_in  = div_req.den;
      end else if (busy_ff) begin
         // remainder stays below the divisor, so it fits the divisor width
         rem_in = qbit ? DIV_DEN_W'(trial - {1'b0, den_ff}) : DIV_DEN_W'(trial);
         num_in = {num_ff[DIV_NUM_W-2:0], qbit};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      num_ff <= num_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign div_rsp.busy = busy_ff;
   assign div_rsp.done = done_ff;
   assign div_rsp.quot = num_ff;

endmodule

`default_nettype wire

// File: rtl/rcg_bin_mem.sv
`timescale 1ns / 1ps
`default_nettype none

module rcg_bin_mem (
   input  wire logic             clock,
   input  rcg_pkg::mem_req_type  mem_req,
   output logic [31:0]           rdata
);
   import rcg_pkg::*;

   logic [31:0] bin_mem_ff [(1 << ADDR_W)];
   logic [31:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (mem_req.we) begin
         bin_mem_ff[mem_req.waddr] <= mem_req.wdata;
      end
      if (mem_req.re) begin
         rdata_ff <= bin_mem_ff[mem_req.raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// File: rtl/rect_coverage_congestion_grid.sv
`timescale 1ns / 1ps
`default_nettype none

// channel   dir   handshake              payload
// req       in    req_tvalid/req_tready  tuser opcode, tdata box, weight, read bin
// rsp       out   rsp_tvalid/rsp_tready  tdata utilization, status
// csr       in    csr_we                 csr_addr index, csr_wdata value
//
// one item at a time; a read is one memory read, a clear a sweep of all 2**ADDR_W bins
// an add first runs five divisions for utilization and bin range, then
// reads and writes each bin, with one more division per edge bin; the 48-step shared
// divider and the single memory port set the pace
// after reset a sweep zeroes all 2**ADDR_W bins, req_tready low
// a finished result waits in the output register; the next item is taken meanwhile

module rect_coverage_congestion_grid (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [1:0]  req_tuser,   // opcode
   input  wire logic [95:0] req_tdata,   // layer, box_ll_x, box_ll_y, box_ur_x, box_ur_y,
                                         // weight, read_bin_x, read_bin_y, zero pad
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [39:0]      rsp_tdata,   // utilization, status, zero pad
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_addr,
   input  wire logic [31:0] csr_wdata
);
   import rcg_pkg::*;

   // input fields
   logic [1:0]  req_layer;
   logic [15:0] req_llx, req_lly, req_urx, req_ury, req_weight;
   logic [5:0]  req_rx, req_ry;

   assign req_layer  = req_tdata[1:0];
   assign req_llx    = req_tdata[17:2];
   assign req_lly    = req_tdata[33:18];
   assign req_urx    = req_tdata[49:34];
   assign req_ury    = req_tdata[65:50];
   assign req_weight = req_tdata[81:66];
   assign req_rx     = req_tdata[87:82];
   assign req_ry     = req_tdata[93:88];

   // configuration registers
   logic [15:0] bw_ff, bh_ff;
   logic [31:0] ba_ff;
   logic [15:0] bw_eff, bh_eff;
   logic [31:0] ba_eff;

   always_ff @(posedge clock) begin
      if (reset) begin
         bw_ff <= 16'd1024;
         bh_ff <= 16'd1024;
         ba_ff <= 32'd1048576;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_BIN_WIDTH:  bw_ff <= csr_wdata[15:0];
            CSR_BIN_HEIGHT: bh_ff <= csr_wdata[15:0];
            CSR_BIN_AREA:   ba_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // a zero register acts as one
   assign bw_eff = (bw_ff == '0) ? 16'd1 : bw_ff;
   assign bh_eff = (bh_ff == '0) ? 16'd1 : bh_ff;
   assign ba_eff = (ba_ff == '0) ? 32'd1 : ba_ff;

   // datapath and control state
   state_type    state_ff, state_in;
   div_sel_type  sel_ff, sel_in;
   logic         clr_rsp_ff, clr_rsp_in;
   logic [ADDR_W-1:0] clr_addr_ff, clr_addr_in;
   logic [1:0]   layer_ff, layer_in;
   logic [15:0]  llx_ff, llx_in, lly_ff, lly_in, urx_ff, urx_in, ury_ff, ury_in;
   logic [15:0]  weight_ff, weight_in, w_ff, w_in, h_ff, h_in;
   logic [32:0]  prod_ff, prod_in;
   logic [31:0]  area_ff, area_in;
   logic [31:0]  util_ff, util_in;
   logic [31:0]  res_ff, res_in;
   logic [1:0]   status_ff, status_in;
   logic [15:0]  xl_ff, xl_in, yl_ff, yl_in;
   logic [CNT_W-1:0] xu_ff, xu_in, yu_ff, yu_in;
   logic [IDX_W-1:0] x_ff, x_in, y_ff, y_in;
   logic [BASE_W-1:0] bx0_ff, bx0_in, by0_ff, by0_in;
   logic [15:0]  ox_ff, ox_in, oy_ff, oy_in;
   logic [31:0]  ovl_ff, ovl_in;
   logic [31:0]  frac_ff, frac_in;
   logic [63:0]  gmul_ff, gmul_in;
   logic [31:0]  gain_ff, gain_in;
   logic         rsp_valid_ff, rsp_valid_in;
   logic [31:0]  rsp_util_ff, rsp_util_in;
   logic [1:0]   rsp_status_ff, rsp_status_in;

   div_req_type  div_req;
   div_rsp_type  div_rsp;
   mem_req_type  mem_req;
   logic [31:0]  mem_rdata;

   // scratch
   logic [31:0]       q_sat;
   logic [16:0]       q_up;
   logic [CNT_W-1:0]  q_clip;
   logic              interior;
   logic [BASE_W-1:0] bx1, by1, lox, hix, loy, hiy;
   logic [32:0]       acc_sum;

   rcg_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   rcg_bin_mem u_mem (
      .clock   (clock),
      .mem_req (mem_req),
      .rdata   (mem_rdata)
   );

   assign req_tready = (state_ff == S_IDLE);

   // saturated quotient and clipped upper bin bound
   assign q_sat  = (|div_rsp.quot[DIV_NUM_W-1:32]) ? '1 : div_rsp.quot[31:0];
   assign q_up   = {1'b0, div_rsp.quot[15:0]} + 17'd1;
   assign q_clip = (q_up > 17'(GRID_DIM)) ? CNT_W'(GRID_DIM) : CNT_W'(q_up);

   // bin strictly inside the covered range in both directions
   assign interior = (xl_ff < 16'(x_ff)) && ((CNT_W'(x_ff) + 1'b1) < xu_ff) &&
                     (yl_ff < 16'(y_ff)) && ((CNT_W'(y_ff) + 1'b1) < yu_ff);

   // overlap of the box with the current bin
   assign bx1 = bx0_ff + BASE_W'(bw_eff);
   assign by1 = by0_ff + BASE_W'(bh_eff);
   assign lox = (BASE_W'(llx_ff) > bx0_ff) ? BASE_W'(llx_ff) : bx0_ff;
   assign hix = (BASE_W'(urx_ff) < bx1)    ? BASE_W'(urx_ff) : bx1;
   assign loy = (BASE_W'(lly_ff) > by0_ff) ? BASE_W'(lly_ff) : by0_ff;
   assign hiy = (BASE_W'(ury_ff) < by1)    ? BASE_W'(ury_ff) : by1;

   assign acc_sum = {1'b0, mem_rdata} + {1'b0, gain_ff};

   always_comb begin
      state_in      = state_ff;
      sel_in        = sel_ff;
      clr_rsp_in    = clr_rsp_ff;
      clr_addr_in   = clr_addr_ff;
      layer_in      = layer_ff;
      llx_in        = llx_ff;
      lly_in        = lly_ff;
      urx_in        = urx_ff;
      ury_in        = ury_ff;
      weight_in     = weight_ff;
      w_in          = w_ff;
      h_in          = h_ff;
      prod_in       = prod_ff;
      area_in       = area_ff;
      util_in       = util_ff;
      res_in        = res_ff;
      status_in     = status_ff;
      xl_in         = xl_ff;
      yl_in         = yl_ff;
      xu_in         = xu_ff;
      yu_in         = yu_ff;
      x_in          = x_ff;
      y_in          = y_ff;
      bx0_in        = bx0_ff;
      by0_in        = by0_ff;
      ox_in         = ox_ff;
      oy_in         = oy_ff;
      ovl_in        = ovl_ff;
      frac_in       = frac_ff;
      gmul_in       = gmul_ff;
      gain_in       = gain_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_util_in   = rsp_util_ff;
      rsp_status_in = rsp_status_ff;
      div_req       = '0;
      mem_req       = '0;

      unique case (state_ff)
         // zero sweep after reset or on a clear item
         S_CLR: begin
            mem_req.we    = 1'b1;
            mem_req.waddr = clr_addr_ff;
            mem_req.wdata = '0;
            clr_addr_in   = clr_addr_ff + 1'b1;
            if (clr_addr_ff == '1) begin
               state_in = clr_rsp_ff ? S_DONE : S_IDLE;
            end
         end

         S_IDLE: begin
            if (req_tvalid) begin
               layer_in  = req_layer;
               llx_in    = req_llx;
               lly_in    = req_lly;
               urx_in    = req_urx;
               ury_in    = req_ury;
               weight_in = req_weight;
               w_in      = req_urx - req_llx;
               h_in      = req_ury - req_lly;
               res_in    = '0;
               status_in = ST_DONE;
               state_in  = S_DONE;
               unique case (req_tuser)
                  OP_ADD: begin
                     if (req_urx < req_llx || req_ury < req_lly) begin
                        status_in = ST_INVERTED;
                     end else if (req_urx == req_llx || req_ury == req_lly) begin
                        status_in = ST_ZERO;
                     end else if (int'(req_layer) < NUM_LAYERS) begin
                        state_in = S_MUL_SUM;
                     end
                  end
                  OP_READ: begin
                     if (int'(req_layer) < NUM_LAYERS && int'(req_rx) < GRID_DIM &&
                         int'(req_ry) < GRID_DIM) begin
                        mem_req.re    = 1'b1;
                        mem_req.raddr = {req_layer, IDX_W'(req_rx), IDX_W'(req_ry)};
                        state_in      = S_RD_WAIT;
                     end
                  end
                  OP_CLEAR: begin
                     clr_addr_in = '0;
                     clr_rsp_in  = 1'b1;
                     state_in    = S_CLR;
                  end
                  default: ;
               endcase
            end
         end

         S_MUL_SUM: begin
            prod_in  = 33'(weight_ff) * (33'(w_ff) + 33'(h_ff));
            state_in = S_MUL_AREA;
         end

         S_MUL_AREA: begin
            area_in  = 32'(w_ff) * 32'(h_ff);
            sel_in   = DS_UTIL;
            state_in = S_DIV_GO;
         end

         S_DIV_GO: begin
            div_req.start = 1'b1;
            case (sel_ff)
               DS_UTIL: begin
                  div_req.num = {7'd0, prod_ff, 8'd0};
                  div_req.den = area_ff;
               end
               DS_XL: begin
                  div_req.num = DIV_NUM_W'(llx_ff);
                  div_req.den = DIV_DEN_W'(bw_eff);
               end
               DS_YL: begin
                  div_req.num = DIV_NUM_W'(lly_ff);
                  div_req.den = DIV_DEN_W'(bh_eff);
               end
               DS_XU: begin
                  div_req.num = DIV_NUM_W'(urx_ff);
                  div_req.den = DIV_DEN_W'(bw_eff);
               end
               DS_YU: begin
                  div_req.num = DIV_NUM_W'(ury_ff);
                  div_req.den = DIV_DEN_W'(bh_eff);
               end
               default: begin
                  div_req.num = {ovl_ff, 16'd0};
                  div_req.den = ba_eff;
               end
            endcase
            state_in = S_DIV_WAIT;
         end

         S_DIV_WAIT: begin
            if (div_rsp.done) begin
               state_in = S_DIV_GO;
               case (sel_ff)
                  DS_UTIL: begin
                     util_in = q_sat;
                     sel_in  = DS_XL;
                  end
                  DS_XL: begin
                     xl_in  = div_rsp.quot[15:0];
                     sel_in = DS_YL;
                  end
                  DS_YL: begin
                     yl_in  = div_rsp.quot[15:0];
                     sel_in = DS_XU;
                  end
                  DS_XU: begin
                     xu_in  = q_clip;
                     sel_in = DS_YU;
                  end
                  DS_YU: begin
                     yu_in    = q_clip;
                     state_in = S_RANGE;
                  end
                  default: begin
                     frac_in  = q_sat;
                     state_in = S_GAIN_MUL;
                  end
               endcase
            end
         end

         // empty index range leaves the map untouched
         S_RANGE: begin
            x_in = IDX_W'(xl_ff);
            y_in = IDX_W'(yl_ff);
            if ({1'b0, xl_ff} < 17'(xu_ff) && {1'b0, yl_ff} < 17'(yu_ff)) begin
               state_in = S_BIN;
            end else begin
               state_in = S_DONE;
            end
         end

         S_BIN: begin
            if (interior) begin
               gain_in  = util_ff;
               state_in = S_RD;
            end else begin
               state_in = S_EDGE_BASE;
            end
         end

         S_EDGE_BASE: begin
            bx0_in   = BASE_W'(x_ff) * BASE_W'(bw_eff);
            by0_in   = BASE_W'(y_ff) * BASE_W'(bh_eff);
            state_in = S_EDGE_SPAN;
         end

         S_EDGE_SPAN: begin
            ox_in    = (hix > lox) ? 16'(hix - lox) : 16'd0;
            oy_in    = (hiy > loy) ? 16'(hiy - loy) : 16'd0;
            state_in = S_EDGE_AREA;
         end

         S_EDGE_AREA: begin
            ovl_in   = 32'(ox_ff) * 32'(oy_ff);
            sel_in   = DS_FRAC;
            state_in = S_DIV_GO;
         end

         S_GAIN_MUL: begin
            gmul_in  = 64'(util_ff) * 64'(frac_ff);
            state_in = S_GAIN_SAT;
         end

         S_GAIN_SAT: begin
            gain_in  = (|gmul_ff[63:48]) ? '1 : gmul_ff[47:16];
            state_in = S_RD;
         end

         S_RD: begin
            mem_req.re    = 1'b1;
            mem_req.raddr = {layer_ff, x_ff, y_ff};
            state_in      = S_WR;
         end

         // saturating accumulate, then step to the next bin
         S_WR: begin
            mem_req.we    = 1'b1;
            mem_req.waddr = {layer_ff, x_ff, y_ff};
            mem_req.wdata = acc_sum[32] ? '1 : acc_sum[31:0];
            if ((CNT_W'(y_ff) + 1'b1) < yu_ff) begin
               y_in     = y_ff + 1'b1;
               state_in = S_BIN;
            end else if ((CNT_W'(x_ff) + 1'b1) < xu_ff) begin
               x_in     = x_ff + 1'b1;
               y_in     = IDX_W'(yl_ff);
               state_in = S_BIN;
            end else begin
               state_in = S_DONE;
            end
         end

         S_RD_WAIT: begin
            res_in   = mem_rdata;
            state_in = S_DONE;
         end

         // hand the result to the output register once it is free
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_util_in   = res_ff;
               rsp_status_in = status_ff;
               clr_rsp_in    = 1'b0;
               state_in      = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLR;
         clr_rsp_ff   <= 1'b0;
         clr_addr_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_rsp_ff   <= clr_rsp_in;
         clr_addr_ff  <= clr_addr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      sel_ff        <= sel_in;
      layer_ff      <= layer_in;
      llx_ff        <= llx_in;
      lly_ff        <= lly_in;
      urx_ff        <= urx_in;
      ury_ff        <= ury_in;
      weight_ff     <= weight_in;
      w_ff          <= w_in;
      h_ff          <= h_in;
      prod_ff       <= prod_in;
      area_ff       <= area_in;
      util_ff       <= util_in;
      res_ff        <= res_in;
      status_ff     <= status_in;
      xl_ff         <= xl_in;
      yl_ff         <= yl_in;
      xu_ff         <= xu_in;
      yu_ff         <= yu_in;
      x_ff          <= x_in;
      y_ff          <= y_in;
      bx0_ff        <= bx0_in;
      by0_ff        <= by0_in;
      ox_ff         <= ox_in;
      oy_ff         <= oy_in;
      ovl_ff        <= ovl_in;
      frac_ff       <= frac_in;
      gmul_ff       <= gmul_in;
      gain_ff       <= gain_in;
      rsp_util_ff   <= rsp_util_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, rsp_status_ff, rsp_util_ff};

`ifndef NO_ASSERTIONS
   // the divider is never restarted while a division runs
   a_div_start_idle: assert property (@(posedge clock) disable iff (reset)
      div_req.start |-> !div_rsp.busy)
      else $error("divider started while busy");

   // the bin walk stays inside the clipped index range
   a_bin_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_BIN) |-> ((CNT_W'(x_ff) < xu_ff) && (CNT_W'(y_ff) < yu_ff)))
      else $error("bin walk left its range");

   // memory writes come only from the zero sweep or a bin update
   a_write_source: assert property (@(posedge clock) disable iff (reset)
      mem_req.we |-> (state_ff == S_CLR || state_ff == S_WR))
      else $error("stray memory write");
`endif

endmodule

`default_nettype wire

// File: test/tb_rect_coverage_congestion_grid.sv
`timescale 1ns / 1ps

module tb_rect_coverage_congestion_grid;
   import rcg_pkg::*;

   localparam int MAX_CYCLES = 4000000;
   localparam int MAP_WORDS  = NUM_LAYERS * GRID_DIM * GRID_DIM;
   localparam logic [1:0] OP_UNUSED = 2'd3;

   typedef struct {
      logic [1:0]  opcode;
      logic [1:0]  layer;
      logic [15:0] ll_x;
      logic [15:0] ll_y;
      logic [15:0] ur_x;
      logic [15:0] ur_y;
      logic [15:0] weight;
      logic [5:0]  rd_x;
      logic [5:0]  rd_y;
   } net_item_type;

   typedef struct {
      logic [31:0] util;
      logic [1:0]  status;
   } bin_result_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [1:0]  req_tuser;
   logic [95:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [39:0] rsp_tdata;
   logic        csr_we;
   logic [1:0]  csr_addr;
   logic [31:0] csr_wdata;

   // scoreboard state
   net_item_type   pending_items[$];
   bin_result_type expected_results[$];
   net_item_type   held_item;
   logic [31:0] util_map [0:MAP_WORDS-1];
   logic [15:0] cfg_bin_w;
   logic [15:0] cfg_bin_h;
   logic [31:0] cfg_bin_area;
   int          err_count;
   int          cycle_count;
   int          req_gap;
   int          rsp_gap;
   bit          no_idle;
   // last add target, used to aim reads at touched bins
   int          last_bx;
   int          last_by;
   logic [1:0]  last_layer;

   rect_coverage_congestion_grid u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // gap lengths: mostly none or short, sometimes long
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (no_idle || r < 55)
         return 0;
      if (r < 90)
         return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   function automatic logic [63:0] clip_span(logic [63:0] lo, logic [63:0] hi,
                                             logic [63:0] b0, logic [63:0] b1);
      logic [63:0] a;
      logic [63:0] b;
      a = (lo > b0) ? lo : b0;
      b = (hi < b1) ? hi : b1;
      return (b > a) ? b - a : 64'd0;
   endfunction

   function automatic logic [63:0] sat_u32(logic [63:0] v);
      return (v > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : v;
   endfunction

   // spread one net box over the map, or serve a read / clear
   function automatic bin_result_type apply_grid_item(net_item_type it);
      bin_result_type res;
      logic [63:0] bw, bh, ba, w, h, util, ox, oy, frac, gain;
      int unsigned xl, xu, yl, yu, idx;
      res.util   = '0;
      res.status = ST_DONE;
      bw = (cfg_bin_w == 0) ? 64'd1 : 64'(cfg_bin_w);
      bh = (cfg_bin_h == 0) ? 64'd1 : 64'(cfg_bin_h);
      ba = (cfg_bin_area == 0) ? 64'd1 : 64'(cfg_bin_area);
      if (it.opcode == OP_ADD) begin
         // inverted check comes before the zero-area check
         if (it.ur_x < it.ll_x || it.ur_y < it.ll_y) begin
            res.status = ST_INVERTED;
         end else if (it.ur_x == it.ll_x || it.ur_y == it.ll_y) begin
            res.status = ST_ZERO;
         end else begin
            w    = 64'(it.ur_x - it.ll_x);
            h    = 64'(it.ur_y - it.ll_y);
            util = sat_u32(((64'(it.weight) * (w + h)) << 8) / (w * h));
            xl   = 32'(64'(it.ll_x) / bw);
            yl   = 32'(64'(it.ll_y) / bh);
            xu   = 32'(64'(it.ur_x) / bw) + 1;
            yu   = 32'(64'(it.ur_y) / bh) + 1;
            if (xu > GRID_DIM) xu = GRID_DIM;
            if (yu > GRID_DIM) yu = GRID_DIM;
            for (int unsigned x = xl; x < xu; x++) begin
               for (int unsigned y = yl; y < yu; y++) begin
                  if (xl < x && x + 1 < xu && yl < y && y + 1 < yu) begin
                     gain = util;
                  end else begin
                     ox   = clip_span(it.ll_x, it.ur_x, x * bw, (x + 1) * bw);
                     oy   = clip_span(it.ll_y, it.ur_y, y * bh, (y + 1) * bh);
                     frac = sat_u32(((ox * oy) << 16) / ba);
                     gain = sat_u32((util * frac) >> 16);
                  end
                  idx = (it.layer * GRID_DIM + x) * GRID_DIM + y;
                  util_map[idx] = 32'(sat_u32(64'(util_map[idx]) + gain));
               end
            end
         end
      end else if (it.opcode == OP_READ) begin
         res.util = util_map[(it.layer * GRID_DIM + it.rd_x) * GRID_DIM + it.rd_y];
      end else if (it.opcode == OP_CLEAR) begin
         for (int i = 0; i < MAP_WORDS; i++)
            util_map[i] = '0;
      end
      return res;
   endfunction

   // request driver: take from pending_items, predict on acceptance
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tuser  <= '0;
         req_tdata  <= '0;
         req_gap    <= 0;
      end else begin
         if (req_tvalid && req_tready)
            expected_results.push_back(apply_grid_item(held_item));
         if (!req_tvalid || req_tready) begin
            if (req_gap > 0) begin
               req_gap    <= req_gap - 1;
               req_tvalid <= 1'b0;
            end else if (pending_items.size() > 0) begin
               held_item = pending_items.pop_front();
               req_tvalid <= 1'b1;
               req_tuser  <= held_item.opcode;
               req_tdata  <= {2'b00, held_item.rd_y, held_item.rd_x, held_item.weight,
                              held_item.ur_y, held_item.ur_x, held_item.ll_y,
                              held_item.ll_x, held_item.layer};
               req_gap    <= pick_gap();
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // result monitor with random back-pressure
   always @(posedge clock) begin
      bin_result_type exp_res;
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_gap    <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_results.size() == 0) begin
               $error("unexpected result: utilization %h status %0d",
                      rsp_tdata[31:0], rsp_tdata[33:32]);
               err_count++;
            end else begin
               exp_res = expected_results.pop_front();
               if (rsp_tdata[31:0] !== exp_res.util) begin
                  $error("utilization: expected %h, got %h", exp_res.util, rsp_tdata[31:0]);
                  err_count++;
               end
               if (rsp_tdata[33:32] !== exp_res.status) begin
                  $error("status: expected %0d, got %0d", exp_res.status, rsp_tdata[33:32]);
                  err_count++;
               end
            end
         end
         if (rsp_gap > 0) begin
            rsp_gap    <= rsp_gap - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            rsp_gap    <= pick_gap();
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > MAX_CYCLES) begin
         $display("Verification failed");
         $finish;
      end
   end

   task automatic queue_item(logic [1:0] op, logic [1:0] layer, int llx, int lly,
                             int urx, int ury, int wt, int rx, int ry);
      net_item_type it;
      it.opcode = op;
      it.layer  = layer;
      it.ll_x   = 16'(llx);
      it.ll_y   = 16'(lly);
      it.ur_x   = 16'(urx);
      it.ur_y   = 16'(ury);
      it.weight = 16'(wt);
      it.rd_x   = 6'(rx);
      it.rd_y   = 6'(ry);
      pending_items.push_back(it);
   endtask

   // wait until every queued item has been taken and answered;
   // checked between edges so that the driver's updates have settled
   task automatic wait_drained();
      @(negedge clock);
      while (pending_items.size() > 0 || req_tvalid || expected_results.size() > 0)
         @(negedge clock);
   endtask

   task automatic write_csr(logic [1:0] addr, logic [31:0] data);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= data;
      @(posedge clock);
      csr_we    <= 1'b0;
      if (addr == CSR_BIN_WIDTH)  cfg_bin_w    = data[15:0];
      if (addr == CSR_BIN_HEIGHT) cfg_bin_h    = data[15:0];
      if (addr == CSR_BIN_AREA)   cfg_bin_area = data;
   endtask

   task automatic set_bins(int bw, int bh, logic [31:0] area);
      wait_drained();
      repeat (20) @(posedge clock);
      write_csr(CSR_BIN_WIDTH, 32'(bw));
      write_csr(CSR_BIN_HEIGHT, 32'(bh));
      write_csr(CSR_BIN_AREA, area);
   endtask

   // one box corner and extent along an axis, a few bins wide at most
   task automatic pick_span(int bin_sz, output int lo, output int hi);
      int b;
      int span;
      b = (bin_sz == 0) ? 1 : bin_sz;
      if ($urandom_range(0, 9) < 3)
         lo = $urandom_range(0, 65535);
      else
         lo = $urandom_range(0, 63) * b + $urandom_range(0, b - 1);
      if (lo > 65535) lo = $urandom_range(0, 65535);
      span = $urandom_range(1, 3 * b);
      if (lo == 65535) lo = 65534;
      hi = (lo + span > 65535) ? 65535 : lo + span;
   endtask

   task automatic queue_random(int count);
      int r, llx, lly, urx, ury, tmp;
      logic [1:0] layer;
      for (int i = 0; i < count; i++) begin
         r     = $urandom_range(0, 199);
         layer = 2'($urandom_range(0, 3));
         if (r < 110) begin
            // well-formed add
            pick_span(cfg_bin_w, llx, urx);
            pick_span(cfg_bin_h, lly, ury);
            last_bx    = llx / ((cfg_bin_w == 0) ? 1 : cfg_bin_w);
            last_by    = lly / ((cfg_bin_h == 0) ? 1 : cfg_bin_h);
            last_layer = layer;
            queue_item(OP_ADD, layer, llx, lly, urx, ury, $urandom_range(0, 65535),
                       $urandom_range(0, 63), $urandom_range(0, 63));
         end else if (r < 170) begin
            // read, mostly near the last box
            if (r < 150 && last_bx < GRID_DIM && last_by < GRID_DIM)
               queue_item(OP_READ, last_layer, $urandom, $urandom, $urandom, $urandom,
                          $urandom, last_bx + $urandom_range(0, 1),
                          last_by + $urandom_range(0, 1));
            else
               queue_item(OP_READ, layer, $urandom, $urandom, $urandom, $urandom,
                          $urandom, $urandom_range(0, 63), $urandom_range(0, 63));
         end else if (r < 190) begin
            // broken box: inverted or flat
            pick_span(cfg_bin_w, llx, urx);
            pick_span(cfg_bin_h, lly, ury);
            if (r < 180) begin
               tmp = llx; llx = urx; urx = tmp;
            end else begin
               ury = lly;
            end
            queue_item(OP_ADD, layer, llx, lly, urx, ury, $urandom_range(0, 65535), 0, 0);
         end else if (r < 198) begin
            queue_item(OP_UNUSED, layer, $urandom, $urandom, $urandom, $urandom, $urandom,
                       $urandom, $urandom);
         end else begin
            queue_item(OP_CLEAR, layer, $urandom, $urandom, $urandom, $urandom,
                       $urandom, $urandom, $urandom);
         end
      end
   endtask

   initial begin
      reset        = 1'b1;
      csr_we       = 1'b0;
      csr_addr     = '0;
      csr_wdata    = '0;
      err_count    = 0;
      cycle_count  = 0;
      no_idle      = 1'b0;
      last_bx      = 0;
      last_by      = 0;
      last_layer   = '0;
      cfg_bin_w    = 16'd1024;
      cfg_bin_h    = 16'd1024;
      cfg_bin_area = 32'd1048576;
      for (int i = 0; i < MAP_WORDS; i++)
         util_map[i] = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed part at the reset geometry
      queue_item(OP_ADD, 2'd0, 0, 0, 65535, 65535, 16'h0100, 0, 0);      // whole map
      queue_item(OP_READ, 2'd0, 0, 0, 0, 0, 0, 0, 0);
      queue_item(OP_READ, 2'd0, 0, 0, 0, 0, 0, 63, 63);
      queue_item(OP_READ, 2'd0, 0, 0, 0, 0, 0, 10, 10);                 // interior bin
      queue_item(OP_ADD, 2'd1, 5000, 100, 4000, 900, 16'h0200, 0, 0);   // inverted x
      queue_item(OP_ADD, 2'd1, 100, 5000, 900, 4000, 16'h0200, 0, 0);   // inverted y
      queue_item(OP_ADD, 2'd1, 900, 300, 100, 300, 16'h0200, 0, 0);     // inverted and flat
      queue_item(OP_ADD, 2'd1, 300, 100, 300, 900, 16'h0200, 0, 0);     // zero width
      queue_item(OP_ADD, 2'd1, 100, 300, 900, 300, 16'h0200, 0, 0);     // zero height
      // box edges on bin boundaries: outer neighbors get no overlap
      queue_item(OP_ADD, 2'd3, 1024, 1024, 2048, 3072, 16'hFFFF, 0, 0);
      queue_item(OP_READ, 2'd3, 0, 0, 0, 0, 0, 1, 1);
      queue_item(OP_READ, 2'd3, 0, 0, 0, 0, 0, 2, 2);
      queue_item(OP_READ, 2'd3, 0, 0, 0, 0, 0, 1, 3);
      queue_item(OP_ADD, 2'd2, 200, 200, 700, 800, 16'h0000, 0, 0);     // zero weight
      queue_item(OP_READ, 2'd2, 0, 0, 0, 0, 0, 0, 0);
      queue_item(OP_ADD, 2'd1, 65534, 65534, 65535, 65535, 16'hFFFF, 63, 63);
      queue_item(OP_ADD, 2'd1, 65534, 65534, 65535, 65535, 16'hFFFF, 63, 63);
      queue_item(OP_READ, 2'd1, 0, 0, 0, 0, 0, 63, 63);
      queue_item(OP_UNUSED, 2'd3, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 63, 63);
      queue_item(OP_CLEAR, 2'd0, 0, 0, 0, 0, 0, 0, 0);
      queue_item(OP_READ, 2'd0, 0, 0, 0, 0, 0, 10, 10);

      // finest grid, everything lands in few bins or past the map
      set_bins(1, 1, 32'd1);
      queue_random(150);

      // coarsest grid with a zero area, frac saturates
      set_bins(65535, 65535, 32'd0);
      queue_random(100);

      // zero registers behave as one; no idling in this phase
      set_bins(0, 0, 32'hFFFF_FFFF);
      no_idle = 1'b1;
      queue_random(60);

      // uneven bins, then hold off until the block is drained
      set_bins(300, 700, 32'd210000);
      no_idle = 1'b0;
      queue_random(100);
      wait_drained();
      queue_random(100);

      set_bins(1024, 1024, 32'd1048576);
      queue_random(200);

      wait_drained();
      repeat (100) @(posedge clock);
      if (pending_items.size() > 0 || expected_results.size() > 0) begin
         $error("results missing: %0d items unsent, %0d results outstanding",
                pending_items.size(), expected_results.size());
         err_count++;
      end
      if (err_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
